FILE: hdl/lsab_pkg.sv
// ----------------------------------------------------------------------------
// Least-served list arbiter package
// Shared widths, codes, request and response types and the saturating
// counter arithmetic used by the arbiter.
// ----------------------------------------------------------------------------
package lsab_pkg;

    // Number of queues served by the arbiter.
    localparam int LISTS      = 8;
    localparam int IDX_W      = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int LVLS       = $clog2(LISTS);
    localparam int LEAVES     = 1 << LVLS;
    localparam int PCNT_W     = $clog2(LISTS + 1);

    // Fixed field widths.
    localparam int MASK_W     = 8;
    localparam int MASK_IDX_W = $clog2(MASK_W);
    localparam int ACTION_W   = 2;
    localparam int CHOSEN_W   = 3;
    localparam int TOTAL_W    = 19;
    localparam int BOOST_W    = 16;
    localparam int CNT_W      = 32;
    localparam int DELTA_W    = BOOST_W + 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BOOST_W;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_AMOUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREF_MASK    = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SELECT     = 2'd0,
        ACT_BOOST_PREF = 2'd1,
        ACT_BOOST_LAST = 2'd2,
        ACT_EVALUATE   = 2'd3
    } t_action;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef t_cnt [LISTS-1:0] t_cnt_arr;

    typedef struct packed {
        t_action           action;
        logic [MASK_W-1:0] nonempty_mask;
        logic [MASK_W-1:0] dead_mask;
        logic [MASK_W-1:0] reliable_mask;
    } t_req;

    typedef struct packed {
        logic [CHOSEN_W-1:0] chosen_queue;
        logic                found;
        logic [TOTAL_W-1:0]  boost_sum;
        logic                is_dead;
        logic                dead_reliable;
    } t_rsp;

    // Winner of the selection tree.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_sel;

    // Update command from the top level to the counter bank.
    typedef struct packed {
        logic              en;
        t_action           action;
        t_sel              sel;
        logic [BOOST_W-1:0] boost;
        logic [MASK_W-1:0] pref_mask;
    } t_cnt_cmd;

    // Queue i has a mask bit only below the mask width.
    function automatic logic mask_bit(input logic [MASK_W-1:0] m, input int i);
        logic [MASK_IDX_W-1:0] b;
        b = i[MASK_IDX_W-1:0];
        return (i < MASK_W) ? m[b] : 1'b0;
    endfunction

    // Signed add that clips at the 32-bit counter bounds.
    function automatic t_cnt sat_add(input t_cnt c, input logic signed [DELTA_W-1:0] d);
        logic signed [CNT_W+1:0] s;
        t_cnt                    r;
        s = (CNT_W+2)'($signed(c)) + (CNT_W+2)'(d);
        if (s[CNT_W+1:CNT_W-1] != 3'b000 && s[CNT_W+1:CNT_W-1] != 3'b111) begin
            r = s[CNT_W+1] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
        end else begin
            r = s[CNT_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/lsab_req_if.sv
// ----------------------------------------------------------------------------
// Arbiter request channel
// Valid/ready channel carrying one arbiter request.
// ----------------------------------------------------------------------------
interface lsab_req_if;
    import lsab_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [MASK_W-1:0]   nonempty_mask;
    logic [MASK_W-1:0]   dead_mask;
    logic [MASK_W-1:0]   reliable_mask;

    modport source (
        output valid, action, nonempty_mask, dead_mask, reliable_mask,
        input  ready
    );
    modport sink (
        input  valid, action, nonempty_mask, dead_mask, reliable_mask,
        output ready
    );
endinterface

FILE: hdl/lsab_rsp_if.sv
// ----------------------------------------------------------------------------
// Arbiter response channel
// Valid/ready channel carrying one arbiter response.
// ----------------------------------------------------------------------------
interface lsab_rsp_if;
    import lsab_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHOSEN_W-1:0] chosen_queue;
    logic                found;
    logic [TOTAL_W-1:0]  boost_sum;
    logic                is_dead;
    logic                dead_reliable;

    modport source (
        output valid, chosen_queue, found, boost_sum, is_dead, dead_reliable,
        input  ready
    );
    modport sink (
        input  valid, chosen_queue, found, boost_sum, is_dead, dead_reliable,
        output ready
    );
endinterface

FILE: hdl/least_served_list_arbiter_with_boost_top.sv
// ----------------------------------------------------------------------------
// Least-served list arbiter with boost
// Top level: request register, single compute stage and response register.
// ----------------------------------------------------------------------------
// The arbiter takes one request per clock cycle while the response side
// drains, and returns exactly one response per request, in order. A request
// is captured in the input register, worked out by the compare tree and the
// counter update, and its response is held in the output register.
// Throughput is one request per cycle while the sink is ready, set by the
// single read-modify-write of the priority counter bank in the compute
// stage; a stalled sink holds the response and then the input register
// before backpressure reaches the request side. Configuration writes take
// effect at the next clock edge; the user must make them while no request
// is in flight, which the block itself does not enforce.
module least_served_list_arbiter_with_boost_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lsab_req_if.sink                          i_req,
    lsab_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [lsab_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lsab_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lsab_pkg::*;

    logic [BOOST_W-1:0] r_boost;
    logic [MASK_W-1:0]  r_pref_mask;
    logic               r_in_valid;
    t_req               r_in;
    logic               r_out_valid;
    t_rsp               r_out;
    t_rsp               n_rsp;
    logic               advance;
    t_cnt_arr           cnt;
    t_sel               sel;
    t_cnt_cmd           cmd;
    logic [PCNT_W-1:0]  pref_cnt;
    logic [TOTAL_W-1:0] total;
    logic               all_dead;
    logic               rel;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boost     <= '0;
            r_pref_mask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BOOST_AMOUNT: r_boost     <= i_cfg_data[BOOST_W-1:0];
                CFG_PREF_MASK:    r_pref_mask <= i_cfg_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The compute stage moves on when the response register is free or drains.
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    // Request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.action        <= t_action'(i_req.action);
            r_in.nonempty_mask <= i_req.nonempty_mask;
            r_in.dead_mask     <= i_req.dead_mask;
            r_in.reliable_mask <= i_req.reliable_mask;
        end
    end

    lsab_select u_select (
        .i_cnt           (cnt),
        .i_nonempty_mask (r_in.nonempty_mask),
        .o_sel           (sel)
    );

    // Counter update command for the request in the compute stage.
    always_comb begin
        cmd.en        = advance;
        cmd.action    = r_in.action;
        cmd.sel       = sel;
        cmd.boost     = r_boost;
        cmd.pref_mask = r_pref_mask;
    end

    lsab_counters u_counters (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_cnt   (cnt)
    );

    // Boost total and dead-end fold.
    always_comb begin
        pref_cnt = '0;
        all_dead = 1'b1;
        rel      = 1'b0;
        for (int i = 0; i < LISTS; i++) begin
            pref_cnt = pref_cnt + PCNT_W'(mask_bit(r_pref_mask, i));
            if (mask_bit(r_in.dead_mask, i)) begin
                if (mask_bit(r_in.reliable_mask, i)) begin
                    rel = 1'b1;
                end
            end else begin
                all_dead = 1'b0;
            end
        end
        total = TOTAL_W'(pref_cnt) * TOTAL_W'(r_boost);
    end

    // Response for the request in the compute stage.
    always_comb begin
        n_rsp = '0;
        case (r_in.action)
            ACT_SELECT: begin
                n_rsp.found        = sel.found;
                n_rsp.chosen_queue = CHOSEN_W'(sel.idx);
            end
            ACT_BOOST_PREF: begin
                n_rsp.boost_sum = total;
            end
            ACT_EVALUATE: begin
                n_rsp.is_dead       = rel || all_dead;
                n_rsp.dead_reliable = rel;
            end
            default: begin
            end
        endcase
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_rsp;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.chosen_queue  = r_out.chosen_queue;
    assign o_rsp.found         = r_out.found;
    assign o_rsp.boost_sum     = r_out.boost_sum;
    assign o_rsp.is_dead       = r_out.is_dead;
    assign o_rsp.dead_reliable = r_out.dead_reliable;

endmodule

FILE: hdl/lsab_select.sv
// ----------------------------------------------------------------------------
// Least-served selection tree
// Finds the non-empty queue with the lowest signed counter through a
// binary compare tree; ties go to the lower queue index.
// ----------------------------------------------------------------------------
module lsab_select (
    input  lsab_pkg::t_cnt_arr            i_cnt,
    input  logic [lsab_pkg::MASK_W-1:0]   i_nonempty_mask,
    output lsab_pkg::t_sel                o_sel
);
    import lsab_pkg::*;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        t_cnt             cnt;
    } t_node;

    t_node lvl [0:LVLS][0:LEAVES-1];

    always_comb begin
        t_node a;
        t_node b;
        lvl = '{default: '0};
        // Leaves: one per queue, padded up to a power of two.
        for (int j = 0; j < LEAVES; j++) begin
            if (j < LISTS) begin
                lvl[0][j].valid = mask_bit(i_nonempty_mask, j);
                lvl[0][j].idx   = IDX_W'(j);
                lvl[0][j].cnt   = i_cnt[j];
            end
        end
        // Each level keeps a valid left node unless a valid right one is strictly lower.
        for (int l = 0; l < LVLS; l++) begin
            for (int j = 0; j < (LEAVES >> (l + 1)); j++) begin
                a = lvl[l][2*j];
                b = lvl[l][2*j+1];
                if (a.valid && (!b.valid || $signed(a.cnt) <= $signed(b.cnt))) begin
                    lvl[l+1][j] = a;
                end else begin
                    lvl[l+1][j] = b;
                end
            end
        end
    end

    assign o_sel.found = lvl[LVLS][0].valid;
    assign o_sel.idx   = lvl[LVLS][0].valid ? lvl[LVLS][0].idx : '0;

endmodule

FILE: hdl/lsab_counters.sv
// ----------------------------------------------------------------------------
// Priority counter bank
// Holds the per-queue signed priority counters and the last used queue,
// and applies select and boost updates with saturation.
// ----------------------------------------------------------------------------
module lsab_counters (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lsab_pkg::t_cnt_cmd i_cmd,
    output lsab_pkg::t_cnt_arr o_cnt
);
    import lsab_pkg::*;

    t_cnt_arr         r_cnt;
    t_cnt_arr         n_cnt;
    logic [IDX_W-1:0] r_last;
    logic [IDX_W-1:0] n_last;
    logic signed [DELTA_W-1:0] boost_neg;

    assign boost_neg = -$signed({2'b00, i_cmd.boost});

    // Next counter values for the request in the compute stage.
    always_comb begin
        n_cnt  = r_cnt;
        n_last = r_last;
        if (i_cmd.en) begin
            case (i_cmd.action)
                ACT_SELECT: begin
                    if (i_cmd.sel.found) begin
                        n_last = i_cmd.sel.idx;
                        for (int i = 0; i < LISTS; i++) begin
                            if (i_cmd.sel.idx == IDX_W'(i)) begin
                                n_cnt[i] = sat_add(r_cnt[i], DELTA_W'(1));
                            end
                        end
                    end
                end
                ACT_BOOST_PREF: begin
                    for (int i = 0; i < LISTS; i++) begin
                        if (mask_bit(i_cmd.pref_mask, i)) begin
                            n_cnt[i] = sat_add(r_cnt[i], boost_neg);
                        end
                    end
                end
                ACT_BOOST_LAST: begin
                    for (int i = 0; i < LISTS; i++) begin
                        if (r_last == IDX_W'(i)) begin
                            n_cnt[i] = sat_add(r_cnt[i], boost_neg);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Counter and last-used registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_last <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_last <= n_last;
        end
    end

    assign o_cnt = r_cnt;

endmodule

FILE: hdl/lsab_checker.sv
// ----------------------------------------------------------------------------
// Arbiter response checker
// Watches the response port of the arbiter and checks that each response
// carries only the fields of one kind of request.
// ----------------------------------------------------------------------------
module lsab_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_ready,
    input  logic [lsab_pkg::CHOSEN_W-1:0]   i_chosen_queue,
    input  logic                            i_found,
    input  logic [lsab_pkg::TOTAL_W-1:0]    i_boost_sum,
    input  logic                            i_is_dead,
    input  logic                            i_dead_reliable
);
    import lsab_pkg::*;

    // A stalled response stays and keeps its payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_chosen_queue) &&
        $stable(i_found) && $stable(i_boost_sum) && $stable(i_is_dead) &&
        $stable(i_dead_reliable))
        else $error("response changed while stalled");

    // A response that carries no grant reports queue zero.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_found |-> i_chosen_queue == '0)
        else $error("queue index without a grant");

    // A grant carries no boost total and no dead-end verdict.
    a_grant_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_found |-> i_boost_sum == '0 && !i_is_dead && !i_dead_reliable)
        else $error("grant mixed with other request fields");

    // A reliable verdict is always a dead-end verdict with no boost total.
    a_reliable_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_dead_reliable |-> i_is_dead && i_boost_sum == '0)
        else $error("reliable verdict without dead end");

endmodule

bind least_served_list_arbiter_with_boost_top lsab_checker u_lsab_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_chosen_queue  (o_rsp.chosen_queue),
    .i_found         (o_rsp.found),
    .i_boost_sum     (o_rsp.boost_sum),
    .i_is_dead       (o_rsp.is_dead),
    .i_dead_reliable (o_rsp.dead_reliable)
);

FILE: tb/least_served_list_arbiter_with_boost_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Least-served list arbiter testbench
// Drives arbiter requests in random bursts against a stalling response sink.
// Each accepted request is run through a cycle-free model of the counter
// bank, and every response is checked field by field in request order. The
// run covers a directed opening, several register settings and a run of
// full boosts on every queue that drives the counters far below zero.
// ----------------------------------------------------------------------------
module least_served_list_arbiter_with_boost_top_tb;
    import lsab_pkg::*;

    localparam longint CREDIT_MAX = 64'sd2147483647;
    localparam longint CREDIT_MIN = -64'sd2147483648;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Stimulus side signals, known from time zero.
    logic                  drv_valid  = 1'b0;
    t_req                  drv_req    = '0;
    logic                  sink_ready = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  req_taken  = 1'b0;

    // Sender burst and receiver stall state.
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    int unsigned sink_mode  = 0;
    int unsigned sink_left  = 0;
    int unsigned sink_phase = 0;

    // Model of the arbiter state and registers.
    logic signed [CNT_W-1:0] queue_credit [LISTS];
    int unsigned             last_served;
    logic [BOOST_W-1:0]      boost_step;
    logic [MASK_W-1:0]       preferred_set;

    t_req        pending_reqs [$];
    t_rsp        awaited_rsps [$];
    int unsigned fail_count = 0;

    lsab_req_if req_ch ();
    lsab_rsp_if rsp_ch ();

    assign req_ch.valid         = drv_valid;
    assign req_ch.action        = drv_req.action;
    assign req_ch.nonempty_mask = drv_req.nonempty_mask;
    assign req_ch.dead_mask     = drv_req.dead_mask;
    assign req_ch.reliable_mask = drv_req.reliable_mask;
    assign rsp_ch.ready         = sink_ready;

    least_served_list_arbiter_with_boost_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Queues beyond the mask width have no bit and read as clear.
    function automatic logic has_bit(input logic [MASK_W-1:0] m, input int q);
        return (q < MASK_W) ? m[q] : 1'b0;
    endfunction

    // Counter update clipped to the signed 32-bit range.
    function automatic logic signed [CNT_W-1:0] clip_credit(
        input logic signed [CNT_W-1:0] c, input longint delta);
        longint s;
        s = longint'(c) + delta;
        if (s > CREDIT_MAX) s = CREDIT_MAX;
        if (s < CREDIT_MIN) s = CREDIT_MIN;
        return s[CNT_W-1:0];
    endfunction

    // Works out the response to one request and updates the model state.
    function automatic t_rsp arbitrate(input t_req r);
        t_rsp        o;
        int          best;
        logic        have;
        logic        all_dead;
        logic        rel;
        int unsigned total;
        o = '0;
        case (r.action)
            ACT_SELECT: begin
                have = 1'b0;
                best = 0;
                for (int q = 0; q < LISTS; q++) begin
                    if (has_bit(r.nonempty_mask, q) &&
                        (!have || queue_credit[q] < queue_credit[best])) begin
                        best = q;
                        have = 1'b1;
                    end
                end
                if (have) begin
                    last_served = best;
                    queue_credit[best] = clip_credit(queue_credit[best], 1);
                    o.chosen_queue = CHOSEN_W'(best);
                    o.found = 1'b1;
                end
            end
            ACT_BOOST_PREF: begin
                total = 0;
                for (int q = 0; q < LISTS; q++) begin
                    if (has_bit(preferred_set, q)) begin
                        queue_credit[q] = clip_credit(queue_credit[q],
                                                      -longint'(boost_step));
                        total += boost_step;
                    end
                end
                o.boost_sum = TOTAL_W'(total);
            end
            ACT_BOOST_LAST: begin
                if (last_served < LISTS) begin
                    queue_credit[last_served] =
                        clip_credit(queue_credit[last_served], -longint'(boost_step));
                end
            end
            default: begin
                all_dead = 1'b1;
                rel = 1'b0;
                for (int q = 0; q < LISTS; q++) begin
                    if (has_bit(r.dead_mask, q)) begin
                        if (has_bit(r.reliable_mask, q)) rel = 1'b1;
                    end else begin
                        all_dead = 1'b0;
                    end
                end
                o.dead_reliable = rel;
                o.is_dead = rel | all_dead;
            end
        endcase
        return o;
    endfunction

    function automatic t_req mk(input t_action a, input logic [MASK_W-1:0] ne,
                                input logic [MASK_W-1:0] dm,
                                input logic [MASK_W-1:0] rm);
        t_req r;
        r.action = a;
        r.nonempty_mask = ne;
        r.dead_mask = dm;
        r.reliable_mask = rm;
        return r;
    endfunction

    // Appends one request to the sender's queue.
    task automatic add_req(input t_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Random request with a bias towards the interesting mask shapes.
    function automatic t_req random_request();
        t_req        r;
        int unsigned pick;
        int unsigned k;
        r.nonempty_mask = MASK_W'($urandom_range(0, 255));
        r.dead_mask     = MASK_W'($urandom_range(0, 255));
        r.reliable_mask = MASK_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 40)      r.action = ACT_SELECT;
        else if (pick < 55) r.action = ACT_BOOST_PREF;
        else if (pick < 70) r.action = ACT_BOOST_LAST;
        else                r.action = ACT_EVALUATE;
        k = $urandom_range(0, 7);
        case ($urandom_range(0, 7))
            0: r.nonempty_mask = '0;
            1: r.nonempty_mask = 8'h01 << k;
            2: r.nonempty_mask = 8'hFF;
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: begin
                r.dead_mask = 8'hFF;
                r.reliable_mask = '0;
            end
            1: r.dead_mask = 8'hFF;
            2: r.reliable_mask = ~r.dead_mask;
            3: begin
                r.dead_mask = ~(8'h01 << k);
                r.reliable_mask = 8'h01 << k;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            fail_count++;
        end
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin : req_driver
        int unsigned gap_n;
        int unsigned burst_n;
        gap_n = gap_left;
        burst_n = burst_left;
        if (drv_valid && !req_taken) begin
            // The current request is still waiting to be taken.
        end else if (gap_n != 0) begin
            gap_n--;
            drv_valid <= 1'b0;
        end else if (i_rst_n && pending_reqs.size() != 0) begin
            drv_req <= pending_reqs.pop_front();
            drv_valid <= 1'b1;
            if (burst_n <= 1) begin
                burst_n = $urandom_range(1, 24);
                gap_n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_n--;
            end
        end else begin
            drv_valid <= 1'b0;
        end
        gap_left <= gap_n;
        burst_left <= burst_n;
    end

    // Response sink: switches between free running, random, sparse and
    // periodic stalls.
    always @(negedge i_clk) begin : rsp_sink
        logic rdy;
        case (sink_mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = (sink_phase % 8) < 5;
        endcase
        sink_ready <= rdy;
        sink_phase <= sink_phase + 1;
        if (sink_left == 0) begin
            sink_mode <= $urandom_range(0, 3);
            sink_left <= $urandom_range(16, 200);
        end else begin
            sink_left <= sink_left - 1;
        end
    end

    // Monitor: checks responses in order and predicts each accepted request.
    always @(posedge i_clk) begin : monitor
        t_rsp want;
        if (!i_rst_n) begin
            for (int q = 0; q < LISTS; q++) queue_credit[q] = '0;
            last_served = 0;
            boost_step = '0;
            preferred_set = '0;
            req_taken <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_BOOST_AMOUNT) boost_step = cfg_data;
                else if (cfg_idx == CFG_PREF_MASK) preferred_set = cfg_data[MASK_W-1:0];
            end
            if (rsp_ch.valid && sink_ready) begin
                if (awaited_rsps.size() == 0) begin
                    $display("%0t: unexpected response, expected none, %s %0d found %0d",
                             $time, "actual queue", rsp_ch.chosen_queue, rsp_ch.found);
                    fail_count++;
                end else begin
                    want = awaited_rsps.pop_front();
                    compare_field("chosen_queue", 32'(want.chosen_queue),
                                  32'(rsp_ch.chosen_queue));
                    compare_field("found", 32'(want.found), 32'(rsp_ch.found));
                    compare_field("boost_sum", 32'(want.boost_sum),
                                  32'(rsp_ch.boost_sum));
                    compare_field("is_dead", 32'(want.is_dead), 32'(rsp_ch.is_dead));
                    compare_field("dead_reliable", 32'(want.dead_reliable),
                                  32'(rsp_ch.dead_reliable));
                end
            end
            if (drv_valid && req_ch.ready) begin
                awaited_rsps.insert(awaited_rsps.size(), arbitrate(drv_req));
            end
            req_taken <= drv_valid && req_ch.ready;
        end
    end

    // Waits until every request has gone out and every response is back.
    task automatic drain();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || awaited_rsps.size() != 0 || drv_valid);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Main sequence.
    initial begin
        logic [BOOST_W-1:0] ph_boost [6];
        logic [MASK_W-1:0]  ph_mask [6];
        ph_boost[0] = 16'd1;     ph_mask[0] = 8'h01;
        ph_boost[1] = 16'hFFFF;  ph_mask[1] = 8'hFF;
        ph_boost[2] = 16'd0;     ph_mask[2] = 8'hFF;
        ph_boost[3] = BOOST_W'($urandom_range(0, 65535));
        ph_mask[3]  = MASK_W'($urandom_range(0, 255));
        ph_boost[4] = BOOST_W'($urandom_range(1, 40));
        ph_mask[4]  = 8'h00;
        ph_boost[5] = 16'd300;
        ph_mask[5]  = MASK_W'($urandom_range(0, 255));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Registers still at their reset values.
        add_req(mk(ACT_SELECT, 8'h00, 8'h00, 8'h00));
        add_req(mk(ACT_BOOST_PREF, 8'h00, 8'h00, 8'h00));
        add_req(mk(ACT_BOOST_LAST, 8'h00, 8'h00, 8'h00));
        add_req(mk(ACT_EVALUATE, 8'h00, 8'h00, 8'h00));
        drain();

        // Boost of the last used queue before any queue has been served.
        write_reg(CFG_BOOST_AMOUNT, 16'd7);
        write_reg(CFG_PREF_MASK, 16'h0081);
        add_req(mk(ACT_BOOST_LAST, 8'h00, 8'h00, 8'h00));
        add_req(mk(ACT_SELECT, 8'hFF, 8'h00, 8'h00));
        add_req(mk(ACT_SELECT, 8'h80, 8'h00, 8'h00));
        add_req(mk(ACT_SELECT, 8'h7E, 8'h00, 8'h00));
        add_req(mk(ACT_BOOST_PREF, 8'h00, 8'h00, 8'h00));
        add_req(mk(ACT_BOOST_LAST, 8'h00, 8'h00, 8'h00));
        add_req(mk(ACT_SELECT, 8'hFF, 8'hFF, 8'hFF));
        add_req(mk(ACT_SELECT, 8'h01, 8'h00, 8'h00));
        add_req(mk(ACT_EVALUATE, 8'h00, 8'hFF, 8'h00));
        add_req(mk(ACT_EVALUATE, 8'h00, 8'hFF, 8'hFF));
        add_req(mk(ACT_EVALUATE, 8'h00, 8'h10, 8'h10));
        add_req(mk(ACT_EVALUATE, 8'hFF, 8'h10, 8'hEF));
        add_req(mk(ACT_EVALUATE, 8'h00, 8'hFE, 8'h01));
        add_req(mk(ACT_EVALUATE, 8'h00, 8'h7F, 8'h00));
        add_req(mk(ACT_SELECT, 8'h00, 8'hFF, 8'hFF));
        add_req(mk(ACT_BOOST_PREF, 8'hFF, 8'hFF, 8'hFF));
        drain();

        // Random phases, each under its own register setting.
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_BOOST_AMOUNT, ph_boost[p]);
            write_reg(CFG_PREF_MASK, CFG_DATA_W'(ph_mask[p]));
            for (int n = 0; n < 140; n++) add_req(random_request());
            drain();
        end

        // Full boost on every queue, driving all counters far below zero.
        write_reg(CFG_BOOST_AMOUNT, 16'hFFFF);
        write_reg(CFG_PREF_MASK, 16'h00FF);
        add_req(mk(ACT_SELECT, 8'h20, 8'h00, 8'h00));
        for (int n = 0; n < 40; n++) begin
            add_req(mk(ACT_BOOST_PREF, 8'h00, 8'h00, 8'h00));
        end
        for (int n = 0; n < 3; n++) begin
            add_req(mk(ACT_BOOST_LAST, 8'h00, 8'h00, 8'h00));
        end
        for (int n = 0; n < 40; n++) add_req(random_request());
        drain();

        // Zero boost after the heavy boosting.
        write_reg(CFG_BOOST_AMOUNT, 16'd0);
        write_reg(CFG_PREF_MASK, CFG_DATA_W'($urandom_range(0, 255)));
        for (int n = 0; n < 80; n++) add_req(random_request());
        drain();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    // Safety limit on the run time.
    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: sim.f
hdl/lsab_pkg.sv
hdl/lsab_req_if.sv
hdl/lsab_rsp_if.sv
hdl/lsab_select.sv
hdl/lsab_counters.sv
hdl/least_served_list_arbiter_with_boost_top.sv
hdl/lsab_checker.sv
tb/least_served_list_arbiter_with_boost_top_tb.sv
